### src/rotation_to_quaternion_core_defines.svh
// assertion macros for the rotation to quaternion core
// expects clk and rst_n in the scope where a macro is used
`ifndef ROTATION_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_TO_QUATERNION_CORE_DEFINES_SVH

// same-cycle implication
`define R2Q_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r2q assertion failed");

// next-cycle implication
`define R2Q_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2q assertion failed");

`endif

### src/r2q_pkg.sv
// shared widths, codes, stage records and helper functions
// for the rotation to quaternion core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package r2q_pkg;

    localparam int DATA_W            = 32;
    localparam int FRACTION_BITS_DEF = 30;
    localparam int ARG_W             = 35;
    localparam int DIFF_W            = 33;
    localparam int ROOT_W            = 32;
    localparam int RAD_W             = 2 * ROOT_W;
    localparam int REM_W             = ROOT_W + 2;
    localparam int DEN_W             = ROOT_W + 1;
    localparam int QUO_W             = 34;
    localparam int NUM_W             = 64;
    localparam int SQRT_CELLS        = ROOT_W;
    localparam int DIV_CELLS         = QUO_W;

    // which component comes straight from the square root
    localparam logic [1:0] MAIN_X = 2'd0;
    localparam logic [1:0] MAIN_Y = 2'd1;
    localparam logic [1:0] MAIN_Z = 2'd2;
    localparam logic [1:0] MAIN_W = 2'd3;

    // numerators of the three other components, in x y z w order skipping main
    typedef struct packed {
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic signed [DIFF_W-1:0] d2;
        logic [1:0]               main;
        logic                     degen;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] lo;
        logic [QUO_W-1:0] q;
        logic             neg;
        logic             ovf;
    } dl_t;

    typedef struct packed {
        dl_t               lane0;
        dl_t               lane1;
        dl_t               lane2;
        logic [DEN_W-1:0]  den;
        logic [DATA_W-1:0] mainv;
        logic [1:0]        main;
        logic              degen;
    } dv_t;

    // magnitude * 2^fb + s, split into the starting remainder and the low bits
    function automatic dl_t div_init(logic signed [DIFF_W-1:0] d,
                                     logic [ROOT_W-1:0] root,
                                     logic [DEN_W-1:0] den,
                                     int unsigned fb);
        dl_t              l;
        logic [DIFF_W-1:0] mag;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  hi;
        l.neg = d[DIFF_W-1];
        mag   = l.neg ? (~d + 1'b1) : d;
        num   = (NUM_W'(mag) << fb) + NUM_W'(root);
        hi    = num >> QUO_W;
        l.ovf = (hi >= NUM_W'(den));
        l.r   = l.ovf ? '0 : hi[DEN_W-1:0];
        l.lo  = num[QUO_W-1:0];
        l.q   = '0;
        return l;
    endfunction

    // returns {saturated, value}
    function automatic logic [DATA_W:0] lane_result(dl_t l);
        logic              s;
        logic [DATA_W-1:0] v;
        if (!l.neg)
        begin
            s = l.ovf || (l.q[QUO_W-1:DATA_W-1] != '0);
            v = s ? {1'b0, {(DATA_W-1){1'b1}}} : l.q[DATA_W-1:0];
        end
        else
        begin
            s = l.ovf || (l.q[QUO_W-1:DATA_W] != '0)
                || (l.q[DATA_W-1] && (l.q[DATA_W-2:0] != '0));
            v = s ? {1'b1, {(DATA_W-1){1'b0}}} : (~l.q[DATA_W-1:0] + 1'b1);
        end
        return {s, v};
    endfunction

endpackage

`default_nettype wire

### src/rotation_to_quaternion_core.sv
// top level: rotation matrix to unit quaternion, fixed point
// depends on r2q_pkg, r2q_front, r2q_sqrt_cell, r2q_div_cell and the defines header
//
//   channel   signals                          direction
//   in        in_valid in_ready r00..r22       into block
//   out       out_valid out_ready quat_x..w,   out of block
//             degenerate
//
// one matrix per cycle while the output is not stalled; stages: entry stage,
// 32 square root cells, divider set-up, 34 divider cells and the output register
// each stage holds one word and moves on as soon as the next has room, so
// a stalled output only backs up the stages that are full
// reset clears the stage valid flags only
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_to_quaternion_core_defines.svh"

module rotation_to_quaternion_core #(
    parameter int FRACTION_BITS = r2q_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r00,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r01,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r02,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r10,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r11,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r12,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r20,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r21,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r22,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [r2q_pkg::DATA_W-1:0]       quat_x,
    output logic signed [r2q_pkg::DATA_W-1:0]       quat_y,
    output logic signed [r2q_pkg::DATA_W-1:0]       quat_z,
    output logic signed [r2q_pkg::DATA_W-1:0]       quat_w,
    output logic                                    degenerate
);

    localparam int SN = r2q_pkg::SQRT_CELLS;
    localparam int DN = r2q_pkg::DIV_CELLS;
    localparam int W  = r2q_pkg::DATA_W;

    logic           sq_v   [0:SN];
    logic           sq_rdy [0:SN];
    r2q_pkg::sq_t   sq_d   [0:SN];
    r2q_pkg::side_t sd_d   [0:SN];

    logic           dv_v   [0:DN];
    logic           dv_rdy [0:DN];
    r2q_pkg::dv_t   dv_d   [0:DN];

    r2q_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .r00       (r00),
        .r01       (r01),
        .r02       (r02),
        .r10       (r10),
        .r11       (r11),
        .r12       (r12),
        .r20       (r20),
        .r21       (r21),
        .r22       (r22),
        .out_valid (sq_v[0]),
        .out_ready (sq_rdy[0]),
        .out_sq    (sq_d[0]),
        .out_side  (sd_d[0])
    );

    for (genvar c = 0; c < SN; c++)
    begin : g_sqrt
        r2q_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[c]),
            .in_ready  (sq_rdy[c]),
            .in_sq     (sq_d[c]),
            .in_side   (sd_d[c]),
            .out_valid (sq_v[c+1]),
            .out_ready (sq_rdy[c+1]),
            .out_sq    (sq_d[c+1]),
            .out_side  (sd_d[c+1])
        );
    end

    // divider set-up: denominator 2s, rounding term s folded into the numerator
    logic         prep_valid_reg;
    r2q_pkg::dv_t prep_reg, prep_next;
    logic [r2q_pkg::ROOT_W-1:0] root;

    assign root = sq_d[SN].root;

    always_comb
    begin
        prep_next.den   = {root, 1'b0};
        prep_next.mainv = W'(root >> 1);
        prep_next.main  = sd_d[SN].main;
        prep_next.degen = sd_d[SN].degen;
        prep_next.lane0 = r2q_pkg::div_init(sd_d[SN].d0, root, {root, 1'b0},
                                            FRACTION_BITS);
        prep_next.lane1 = r2q_pkg::div_init(sd_d[SN].d1, root, {root, 1'b0},
                                            FRACTION_BITS);
        prep_next.lane2 = r2q_pkg::div_init(sd_d[SN].d2, root, {root, 1'b0},
                                            FRACTION_BITS);
    end

    assign sq_rdy[SN] = !prep_valid_reg || dv_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (sq_rdy[SN])
            prep_valid_reg <= sq_v[SN];
    end

    always_ff @(posedge clk)
    begin
        if (sq_v[SN] && sq_rdy[SN])
            prep_reg <= prep_next;
    end

    assign dv_v[0] = prep_valid_reg;
    assign dv_d[0] = prep_reg;

    for (genvar c = 0; c < DN; c++)
    begin : g_div
        r2q_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[c]),
            .in_ready  (dv_rdy[c]),
            .in_dv     (dv_d[c]),
            .out_valid (dv_v[c+1]),
            .out_ready (dv_rdy[c+1]),
            .out_dv    (dv_d[c+1])
        );
    end

    // output register: saturation and component placement
    logic         out_valid_reg;
    logic         fin_load;
    logic [W:0]   res0, res1, res2;
    logic [W-1:0] qx_next, qy_next, qz_next, qw_next;
    logic         deg_next;
    logic [W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic         deg_reg;
    r2q_pkg::dv_t fin;

    assign fin        = dv_d[DN];
    assign dv_rdy[DN] = !out_valid_reg || out_ready;
    assign fin_load   = dv_v[DN] && dv_rdy[DN];

    always_comb
    begin
        res0 = r2q_pkg::lane_result(fin.lane0);
        res1 = r2q_pkg::lane_result(fin.lane1);
        res2 = r2q_pkg::lane_result(fin.lane2);

        qx_next = (fin.main == r2q_pkg::MAIN_X) ? fin.mainv : res0[W-1:0];
        qw_next = (fin.main == r2q_pkg::MAIN_W) ? fin.mainv : res2[W-1:0];
        if (fin.main == r2q_pkg::MAIN_Y)
            qy_next = fin.mainv;
        else if (fin.main == r2q_pkg::MAIN_X)
            qy_next = res0[W-1:0];
        else
            qy_next = res1[W-1:0];
        if (fin.main == r2q_pkg::MAIN_Z)
            qz_next = fin.mainv;
        else if (fin.main == r2q_pkg::MAIN_W)
            qz_next = res2[W-1:0];
        else
            qz_next = res1[W-1:0];

        deg_next = fin.degen || res0[W] || res1[W] || res2[W];
        if (fin.degen)
        begin
            qx_next = '0;
            qy_next = '0;
            qz_next = '0;
            qw_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dv_rdy[DN])
            out_valid_reg <= dv_v[DN];
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            qz_reg  <= qz_next;
            qw_reg  <= qw_next;
            deg_reg <= deg_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign quat_x     = qx_reg;
    assign quat_y     = qy_reg;
    assign quat_z     = qz_reg;
    assign quat_w     = qw_reg;
    assign degenerate = deg_reg;

    `R2Q_ASSERT_IMPL(a_root_nonzero, sq_v[SN] && !sd_d[SN].degen, sq_d[SN].root != '0)
    `R2Q_ASSERT_IMPL(a_rem_below_den, dv_v[DN] && !fin.degen, fin.lane0.r < fin.den)
    `R2Q_ASSERT_NEXT(a_degen_zero, fin_load && fin.degen, degenerate && quat_x == '0 && quat_w == '0)

endmodule

`default_nettype wire

### src/r2q_front.sv
// entry stage: trace, branch choice, root argument and numerators
// depends on r2q_pkg
`timescale 1ns / 1ps
`default_nettype none

module r2q_front #(
    parameter int FRACTION_BITS = r2q_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r00,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r01,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r02,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r10,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r11,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r12,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r20,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r21,
    input  wire logic signed [r2q_pkg::DATA_W-1:0]  r22,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output r2q_pkg::sq_t                            out_sq,
    output r2q_pkg::side_t                          out_side
);

    localparam int AW = r2q_pkg::ARG_W;
    localparam int DW = r2q_pkg::DIFF_W;

    logic signed [AW-1:0] e00, e11, e22, one, trace, arg;
    logic [1:0]           main;
    logic                 degen;
    logic                 valid_reg;
    r2q_pkg::sq_t         sq_reg, sq_next;
    r2q_pkg::side_t       side_reg, side_next;

    assign e00 = AW'(r00);
    assign e11 = AW'(r11);
    assign e22 = AW'(r22);
    assign one = AW'(1) <<< FRACTION_BITS;
    assign trace = e00 + e11 + e22;

    always_comb
    begin
        if (trace > 0)
            main = r2q_pkg::MAIN_W;
        else if (e00 < e11)
            main = (e11 < e22) ? r2q_pkg::MAIN_Z : r2q_pkg::MAIN_Y;
        else
            main = (e00 < e22) ? r2q_pkg::MAIN_Z : r2q_pkg::MAIN_X;
    end

    always_comb
    begin
        case (main)
            r2q_pkg::MAIN_W:
            begin
                arg          = trace + one;
                side_next.d0 = DW'(r21) - DW'(r12);
                side_next.d1 = DW'(r02) - DW'(r20);
                side_next.d2 = DW'(r10) - DW'(r01);
            end
            r2q_pkg::MAIN_X:
            begin
                arg          = e00 - e11 - e22 + one;
                side_next.d0 = DW'(r10) + DW'(r01);
                side_next.d1 = DW'(r20) + DW'(r02);
                side_next.d2 = DW'(r21) - DW'(r12);
            end
            r2q_pkg::MAIN_Y:
            begin
                arg          = e11 - e22 - e00 + one;
                side_next.d0 = DW'(r01) + DW'(r10);
                side_next.d1 = DW'(r21) + DW'(r12);
                side_next.d2 = DW'(r02) - DW'(r20);
            end
            default:
            begin
                arg          = e22 - e00 - e11 + one;
                side_next.d0 = DW'(r02) + DW'(r20);
                side_next.d1 = DW'(r12) + DW'(r21);
                side_next.d2 = DW'(r10) - DW'(r01);
            end
        endcase
        degen           = (arg <= 0);
        side_next.main  = main;
        side_next.degen = degen;
        sq_next.rad     = degen ? '0
                          : (r2q_pkg::RAD_W'($unsigned(arg)) << FRACTION_BITS);
        sq_next.rem     = '0;
        sq_next.root    = '0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sq_reg   <= sq_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### src/r2q_sqrt_cell.sv
// one cell of the square root row: settles one root bit per word
// depends on r2q_pkg
`timescale 1ns / 1ps
`default_nettype none

module r2q_sqrt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire r2q_pkg::sq_t    in_sq,
    input  wire r2q_pkg::side_t  in_side,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output r2q_pkg::sq_t         out_sq,
    output r2q_pkg::side_t       out_side
);

    localparam int RW = r2q_pkg::REM_W;

    logic [RW+1:0]  sh, trial;
    logic           take;
    logic           valid_reg;
    r2q_pkg::sq_t   sq_reg, sq_next;
    r2q_pkg::side_t side_reg;

    always_comb
    begin
        sh    = {in_sq.rem, in_sq.rad[r2q_pkg::RAD_W-1 -: 2]};
        trial = (RW+2)'({in_sq.root, 2'b01});
        take  = (sh >= trial);
        sq_next.rem  = take ? RW'(sh - trial) : RW'(sh);
        sq_next.root = {in_sq.root[r2q_pkg::ROOT_W-2:0], take};
        sq_next.rad  = in_sq.rad << 2;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### src/r2q_div_cell.sv
// one cell of the divider row: one quotient bit for each of three lanes
// depends on r2q_pkg
`timescale 1ns / 1ps
`default_nettype none

module r2q_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire r2q_pkg::dv_t  in_dv,
    output logic               out_valid,
    input  wire logic          out_ready,
    output r2q_pkg::dv_t       out_dv
);

    logic         valid_reg;
    r2q_pkg::dv_t dv_reg, dv_next;

    function automatic r2q_pkg::dl_t step(r2q_pkg::dl_t l,
                                          logic [r2q_pkg::DEN_W-1:0] den);
        r2q_pkg::dl_t            n;
        logic [r2q_pkg::DEN_W:0] t;
        logic                    take;
        t      = {l.r, l.lo[r2q_pkg::QUO_W-1]};
        take   = (t >= {1'b0, den});
        n      = l;
        n.r    = take ? r2q_pkg::DEN_W'(t - {1'b0, den}) : r2q_pkg::DEN_W'(t);
        n.lo   = l.lo << 1;
        n.q    = {l.q[r2q_pkg::QUO_W-2:0], take};
        return n;
    endfunction

    always_comb
    begin
        dv_next       = in_dv;
        dv_next.lane0 = step(in_dv.lane0, in_dv.den);
        dv_next.lane1 = step(in_dv.lane1, in_dv.den);
        dv_next.lane2 = step(in_dv.lane2, in_dv.den);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            dv_reg <= dv_next;
    end

    assign out_valid = valid_reg;
    assign out_dv    = dv_reg;

endmodule

`default_nettype wire
